>>> rtl/core/ustar_archive_walker_assert.svh
// assertion macros for the ustar archive walker
// needs i_clk and i_rst_n in the scope of use
`ifndef USTAR_ARCHIVE_WALKER_ASSERT_SVH
`define USTAR_ARCHIVE_WALKER_ASSERT_SVH

// same-cycle implication
`define UAW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ustar archive walker check failed");

// next-cycle implication
`define UAW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ustar archive walker check failed");

`endif

>>> rtl/core/uaw_pkg.sv
// shared constants, types and helpers of the ustar archive walker
// no dependencies
package uaw_pkg;

    localparam int BLOCK_BYTES     = 512;
    localparam int BLOCK_SHIFT     = 9;
    localparam int POS_W           = 9;
    localparam int SIZE_W          = 33;
    localparam int OUT_OFF_W       = 40;
    localparam int BLK_W           = 24;
    localparam int SIZE_DIGITS     = 11;
    localparam int SIZE_AT         = 124;
    localparam int TYPE_AT         = 156;
    localparam int MAGIC_AT        = 257;
    localparam int MAGIC_LEN       = 5;
    localparam int OFFSET_BITS_DEF = 40;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] DIR_TYPE  = 8'h35;
    localparam logic [4:0] OCTAL_HI5 = 5'b00110;

    typedef enum logic [1:0] {
        KIND_FILE = 2'd0,
        KIND_DIR  = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    // one classified archive byte
    typedef struct packed {
        logic                 last;
        logic                 in_size;
        logic [2:0]           digit;
        logic                 bad_digit;
        logic                 is_type;
        logic                 type_dir;
        logic                 magic_bad;
        logic                 nonzero;
        logic [OUT_OFF_W-1:0] off;
    } t_tok;

    typedef struct packed {
        t_kind                kind;
        logic [SIZE_W-1:0]    size;
        logic [OUT_OFF_W-1:0] data_off;
        logic [OUT_OFF_W-1:0] arch_len;
        logic                 magic_ok;
        logic                 digit_err;
    } t_rec;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/uaw_queue.sv
// small first-in first-out queue of packed beats
// uses uaw_pkg for the default depth
module uaw_queue import uaw_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    assign n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= n_wptr;
            end
            if (do_pop) begin
                r_rptr <= n_rptr;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

>>> rtl/core/uaw_front.sv
// front end: block position and archive offset counters, byte classification
// uses uaw_pkg for field offsets and the token type
module uaw_front import uaw_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    output t_tok       o_tok
);

    logic [POS_W-1:0]       r_pos;
    logic [OFFSET_BITS-1:0] r_off;
    logic [OFFSET_BITS-1:0] n_off;
    logic                   is_last;
    logic                   is_octal;
    logic                   in_magic;
    logic [2:0]             magic_idx;

    assign n_off     = r_off + 1'b1;
    assign is_last   = (r_pos == POS_W'(BLOCK_BYTES - 1));
    assign is_octal  = (i_data_byte[7:3] == OCTAL_HI5);
    assign in_magic  = (r_pos >= POS_W'(MAGIC_AT)) && (r_pos < POS_W'(MAGIC_AT + MAGIC_LEN));
    assign magic_idx = 3'(r_pos - POS_W'(MAGIC_AT));

    always_comb begin
        o_tok.last      = is_last;
        o_tok.in_size   = (r_pos >= POS_W'(SIZE_AT)) && (r_pos < POS_W'(SIZE_AT + SIZE_DIGITS));
        o_tok.digit     = is_octal ? i_data_byte[2:0] : 3'd0;
        o_tok.bad_digit = !is_octal;
        o_tok.is_type   = (r_pos == POS_W'(TYPE_AT));
        o_tok.type_dir  = (i_data_byte == DIR_TYPE);
        o_tok.magic_bad = in_magic && (i_data_byte != magic_char(magic_idx));
        o_tok.nonzero   = (i_data_byte != 8'h00);
        o_tok.off       = OUT_OFF_W'(n_off);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_off <= '0;
        end else if (i_accept) begin
            r_pos <= is_last ? '0 : r_pos + 1'b1;
            r_off <= n_off;
        end
    end

endmodule

>>> rtl/core/uaw_back.sv
// back end: walk phase, header field accumulation and record queue
// uses uaw_pkg and uaw_queue
module uaw_back import uaw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_tok_valid,
    input  t_tok i_tok,
    output logic o_tok_pop,
    input  logic i_rec_pop,
    output t_rec o_rec,
    output logic o_rec_empty
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_END    = 2'd2
    } t_phase;

    t_phase             r_phase;
    logic [BLK_W-1:0]   r_blocks;
    logic [SIZE_W-1:0]  r_size, n_size;
    logic               r_dir, n_dir;
    logic               r_magic, n_magic;
    logic               r_bad, n_bad;
    logic               r_allzero, n_allzero;
    logic               r_zpend;
    logic [SIZE_W-1:0]  size_m1;
    logic               hdr, stall, take;
    logic               emit_entry, emit_end;
    logic               rec_full;
    t_rec               rec;

    assign hdr       = (r_phase == PH_HEADER);
    assign stall     = i_tok.last && hdr && rec_full;
    assign take      = i_tok_valid && !stall;
    assign o_tok_pop = take;

    assign n_allzero = r_allzero && !i_tok.nonzero;
    assign n_size    = i_tok.in_size ? {r_size[SIZE_W-4:0], i_tok.digit} : r_size;
    assign n_bad     = r_bad || (i_tok.in_size && i_tok.bad_digit);
    assign n_dir     = i_tok.is_type ? i_tok.type_dir : r_dir;
    assign n_magic   = r_magic && !i_tok.magic_bad;
    assign size_m1   = n_size - SIZE_W'(1);

    assign emit_entry = hdr && i_tok.last && !n_allzero;
    assign emit_end   = hdr && i_tok.last && n_allzero && r_zpend;

    always_comb begin
        rec.kind      = emit_end ? KIND_END : (n_dir ? KIND_DIR : KIND_FILE);
        rec.size      = emit_end ? '0 : n_size;
        rec.data_off  = emit_end ? '0 : i_tok.off;
        rec.arch_len  = emit_end ? i_tok.off : '0;
        rec.magic_ok  = !emit_end && n_magic;
        rec.digit_err = !emit_end && n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_blocks  <= '0;
            r_size    <= '0;
            r_dir     <= 1'b0;
            r_magic   <= 1'b1;
            r_bad     <= 1'b0;
            r_allzero <= 1'b1;
            r_zpend   <= 1'b0;
        end else if (take) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (i_tok.last) begin
                        r_size    <= '0;
                        r_dir     <= 1'b0;
                        r_magic   <= 1'b1;
                        r_bad     <= 1'b0;
                        r_allzero <= 1'b1;
                        if (n_allzero) begin
                            if (r_zpend) begin
                                r_phase <= PH_END;
                                r_zpend <= 1'b0;
                            end else begin
                                r_zpend <= 1'b1;
                            end
                        end else begin
                            r_zpend <= 1'b0;
                            if (!n_dir && (n_size != '0)) begin
                                r_blocks <= BLK_W'(size_m1 >> BLOCK_SHIFT);
                                r_phase  <= PH_DATA;
                            end
                        end
                    end else begin
                        r_size    <= n_size;
                        r_dir     <= n_dir;
                        r_magic   <= n_magic;
                        r_bad     <= n_bad;
                        r_allzero <= n_allzero;
                    end
                end
                PH_DATA: begin
                    if (i_tok.last) begin
                        if (r_blocks == '0) begin
                            r_phase <= PH_HEADER;
                        end else begin
                            r_blocks <= r_blocks - 1'b1;
                        end
                    end
                end
                PH_END: begin
                    r_phase <= PH_END;
                end
                default: begin
                    r_phase <= PH_HEADER;
                end
            endcase
        end
    end

    uaw_queue #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (QUEUE_DEPTH)
    ) u_rec_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take && (emit_entry || emit_end)),
        .i_data  (rec),
        .o_full  (rec_full),
        .i_pop   (i_rec_pop),
        .o_data  (o_rec),
        .o_empty (o_rec_empty)
    );

endmodule

>>> rtl/core/ustar_archive_walker.sv
// top level of the ustar archive walker: front end, token queue, back end
// uses uaw_pkg, uaw_front, uaw_queue, uaw_back and the assertion macro header
//
// Takes one archive byte per beat and sustains one byte per clock when not
// stalled. A byte is classified in the front end and enters a two-beat token
// queue; the back end retires one token per cycle when not stalled, and the
// last token of a header block pushes its record into the record queue. The
// only stall is the last byte of a header-phase block meeting a full
// two-entry record queue. Every non-zero 512-byte header block gives a file
// or directory record; two zero blocks in a row give one end record, after
// which all bytes are dropped until reset. Offsets count modulo 2^OFFSET_BITS.
module ustar_archive_walker import uaw_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_data_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           o_entry_kind,
    output logic [SIZE_W-1:0]    o_file_size,
    output logic [OUT_OFF_W-1:0] o_data_offset,
    output logic [OUT_OFF_W-1:0] o_archive_length,
    output logic                 o_magic_ok,
    output logic                 o_digit_error
);

    t_tok front_tok;
    t_tok back_tok;
    t_rec rec;
    logic tok_empty;
    logic tok_pop;
    logic rec_is_end;
    logic end_fields_ok;
    logic entry_fields_ok;

    uaw_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (push && !full),
        .i_data_byte (i_data_byte),
        .o_tok       (front_tok)
    );

    uaw_queue #(
        .WIDTH ($bits(t_tok)),
        .DEPTH (QUEUE_DEPTH)
    ) u_tok_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_tok),
        .o_full  (full),
        .i_pop   (tok_pop),
        .o_data  (back_tok),
        .o_empty (tok_empty)
    );

    uaw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (!tok_empty),
        .i_tok       (back_tok),
        .o_tok_pop   (tok_pop),
        .i_rec_pop   (pop),
        .o_rec       (rec),
        .o_rec_empty (empty)
    );

    assign o_entry_kind     = rec.kind;
    assign o_file_size      = rec.size;
    assign o_data_offset    = rec.data_off;
    assign o_archive_length = rec.arch_len;
    assign o_magic_ok       = rec.magic_ok;
    assign o_digit_error    = rec.digit_err;

    assign rec_is_end      = (rec.kind == KIND_END);
    assign end_fields_ok   = (rec.size == '0) && (rec.data_off == '0)
                             && (rec.arch_len[8:0] == '0) && !rec.magic_ok && !rec.digit_err;
    assign entry_fields_ok = (rec.arch_len == '0) && (rec.data_off[8:0] == '0);

`include "ustar_archive_walker_assert.svh"

    // end records carry only the total length, on a block boundary
    `UAW_ASSERT_IMP(a_end_fields, !empty && rec_is_end, end_fields_ok)
    // entry records point at a block boundary and carry no length
    `UAW_ASSERT_IMP(a_entry_fields, !empty && !rec_is_end, entry_fields_ok)
    // a token held back by the back end stays at the head of the queue
    `UAW_ASSERT_NXT(a_tok_hold, !tok_empty && !tok_pop, !tok_empty && $stable(back_tok))

endmodule

>>> tb/ustar_walk_checker.sv
`timescale 1ns / 100ps
// checker for the ustar archive walker: follows the byte stream, predicts the records
// and compares every popped beat field by field; uses uaw_pkg for the record type
module ustar_walk_checker import uaw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    input  logic                 full,
    input  logic [7:0]           i_data_byte,
    input  logic                 empty,
    input  logic                 pop,
    input  logic [1:0]           o_entry_kind,
    input  logic [SIZE_W-1:0]    o_file_size,
    input  logic [OUT_OFF_W-1:0] o_data_offset,
    input  logic [OUT_OFF_W-1:0] o_archive_length,
    input  logic                 o_magic_ok,
    input  logic                 o_digit_error,
    output int                   o_fail_count,
    output int                   o_pending_count
);

    localparam int HDR_SIZE_AT   = 124;
    localparam int HDR_SIZE_LEN  = 11;
    localparam int HDR_TYPE_AT   = 156;
    localparam int HDR_MAGIC_AT  = 257;
    localparam int HDR_MAGIC_LEN = 5;
    localparam int BLOCK_LAST    = 511;
    localparam int SKIP_W        = 24;

    localparam logic [7:0]  DIR_CHAR   = "5";
    localparam logic [39:0] MAGIC_WORD = "ustar";

    typedef enum logic [1:0] {
        WALK_HEADER = 2'd0,
        WALK_DATA   = 2'd1,
        WALK_ENDED  = 2'd2
    } t_walk;

    logic [8:0]           pos_in_block;
    logic [OUT_OFF_W-1:0] byte_count;
    t_walk                walk;
    logic [SKIP_W-1:0]    skip_left;
    logic [SIZE_W-1:0]    size_sum;
    logic [7:0]           type_seen;
    logic                 magic_good;
    logic                 digit_bad;
    logic                 zero_so_far;
    logic                 zero_prev;

    t_rec expected_records[$];
    t_rec want;
    int   mismatches = 0;
    int   pending = 0;

    assign o_fail_count    = mismatches;
    assign o_pending_count = pending;

    function automatic void start_header();
        size_sum    = '0;
        type_seen   = '0;
        magic_good  = 1'b1;
        digit_bad   = 1'b0;
        zero_so_far = 1'b1;
    endfunction

    function automatic void restart_walk();
        pos_in_block = '0;
        byte_count   = '0;
        walk         = WALK_HEADER;
        skip_left    = '0;
        zero_prev    = 1'b0;
        start_header();
    endfunction

    // advances the walk by one archive byte and queues the record it completes
    function automatic void walk_byte(input logic [7:0] b);
        logic [2:0]  digit;
        logic [33:0] blocks;
        int          idx;
        t_rec        rec;
        if (walk == WALK_ENDED) return;
        if (walk == WALK_HEADER) begin
            if (b != 8'h00) zero_so_far = 1'b0;
            if (pos_in_block >= HDR_SIZE_AT && pos_in_block < HDR_SIZE_AT + HDR_SIZE_LEN) begin
                digit = 3'd0;
                if (b >= "0" && b <= "7") digit = 3'(b - "0");
                else digit_bad = 1'b1;
                size_sum = (size_sum << 3) + digit;
            end
            if (pos_in_block == HDR_TYPE_AT) type_seen = b;
            if (pos_in_block >= HDR_MAGIC_AT && pos_in_block < HDR_MAGIC_AT + HDR_MAGIC_LEN) begin
                idx = pos_in_block - HDR_MAGIC_AT;
                if (b != MAGIC_WORD[8*(HDR_MAGIC_LEN-1-idx) +: 8]) magic_good = 1'b0;
            end
        end
        byte_count = byte_count + 1'b1;
        if (pos_in_block != BLOCK_LAST) begin
            pos_in_block = pos_in_block + 1'b1;
            return;
        end
        pos_in_block = '0;
        if (walk == WALK_DATA) begin
            if (skip_left == '0) walk = WALK_HEADER;
            else skip_left = skip_left - 1'b1;
            return;
        end
        if (zero_so_far) begin
            if (zero_prev) begin
                rec.kind      = KIND_END;
                rec.size      = '0;
                rec.data_off  = '0;
                rec.arch_len  = byte_count;
                rec.magic_ok  = 1'b0;
                rec.digit_err = 1'b0;
                expected_records.push_back(rec);
                walk      = WALK_ENDED;
                zero_prev = 1'b0;
            end else begin
                zero_prev = 1'b1;
            end
        end else begin
            zero_prev     = 1'b0;
            rec.kind      = (type_seen == DIR_CHAR) ? KIND_DIR : KIND_FILE;
            rec.size      = size_sum;
            rec.data_off  = byte_count;
            rec.arch_len  = '0;
            rec.magic_ok  = magic_good;
            rec.digit_err = digit_bad;
            expected_records.push_back(rec);
            if (type_seen != DIR_CHAR && size_sum != '0) begin
                blocks    = ({1'b0, size_sum} + 34'd511) >> 9;
                skip_left = SKIP_W'(blocks - 1'b1);
                walk      = WALK_DATA;
            end
        end
        start_header();
    endfunction

    function automatic void compare_field(input string what, input logic [39:0] want_v,
                                          input logic [39:0] got_v);
        if (got_v !== want_v) begin
            mismatches = mismatches + 1;
            $display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_walk();
            expected_records.delete();
        end else begin
            if (push && !full) walk_byte(i_data_byte);
            if (pop && !empty) begin
                if (expected_records.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t: record beat with none expected, kind expected none got %0h",
                             $time, o_entry_kind);
                end else begin
                    want = expected_records.pop_front();
                    compare_field("entry_kind", want.kind, o_entry_kind);
                    compare_field("file_size", want.size, o_file_size);
                    compare_field("data_offset", want.data_off, o_data_offset);
                    compare_field("archive_length", want.arch_len, o_archive_length);
                    compare_field("magic_ok", want.magic_ok, o_magic_ok);
                    compare_field("digit_error", want.digit_err, o_digit_error);
                end
            end
        end
        pending = expected_records.size();
    end

endmodule

>>> tb/tb_ustar_archive_walker.sv
`timescale 1ns / 100ps
// top of the ustar archive walker testbench: clock, reset, archive byte stimulus and verdict
// depends on uaw_pkg, ustar_archive_walker and ustar_walk_checker
module tb_ustar_archive_walker;
    import uaw_pkg::*;

    localparam int LIMIT_CYCLES = 2500000;
    localparam int HOLD_CYCLES  = 4000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [7:0]  DIR_CHAR   = "5";
    localparam logic [39:0] MAGIC_WORD = "ustar";

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 pop = 1'b0;
    logic [7:0]           i_data_byte = 8'h00;
    logic                 full;
    logic                 empty;
    logic [1:0]           o_entry_kind;
    logic [SIZE_W-1:0]    o_file_size;
    logic [OUT_OFF_W-1:0] o_data_offset;
    logic [OUT_OFF_W-1:0] o_archive_length;
    logic                 o_magic_ok;
    logic                 o_digit_error;
    int                   fail_count;
    int                   pending_count;

    bit   tx_idle = 1'b1;
    bit   rx_idle = 1'b1;
    bit   hold_req = 1'b0;
    int   hold_left = 0;
    int   cycles = 0;
    logic [7:0] blk [0:511];

    ustar_archive_walker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (i_data_byte),
        .empty            (empty),
        .pop              (pop),
        .o_entry_kind     (o_entry_kind),
        .o_file_size      (o_file_size),
        .o_data_offset    (o_data_offset),
        .o_archive_length (o_archive_length),
        .o_magic_ok       (o_magic_ok),
        .o_digit_error    (o_digit_error)
    );

    ustar_walk_checker chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (i_data_byte),
        .empty            (empty),
        .pop              (pop),
        .o_entry_kind     (o_entry_kind),
        .o_file_size      (o_file_size),
        .o_data_offset    (o_data_offset),
        .o_archive_length (o_archive_length),
        .o_magic_ok       (o_magic_ok),
        .o_digit_error    (o_digit_error),
        .o_fail_count     (fail_count),
        .o_pending_count  (pending_count)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random pops, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= !(rx_idle && $urandom_range(0, 99) < 20);
            end
        end
    end

    function automatic logic [7:0] non_octal_byte();
        logic [7:0] c;
        c = 8'($urandom);
        while (c >= "0" && c <= "7") c = 8'($urandom);
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while (tx_idle && $urandom_range(0, 99) < 20) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_block();
        for (int i = 0; i < 512; i++) send_byte(blk[i]);
    endtask

    task automatic fill_data(input bit zero);
        for (int i = 0; i < 512; i++) blk[i] = zero ? 8'h00 : 8'($urandom);
    endtask

    task automatic build_header(input logic [7:0] type_ch, input logic [32:0] size_val,
                                input bit noisy, input bit magic_bad);
        logic [2:0] digit;
        int k;
        for (int i = 0; i < 512; i++)
            blk[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
        for (int d = 0; d < 11; d++) begin
            digit = size_val[3*(10-d) +: 3];
            blk[124+d] = "0" + digit;
            // a non-octal digit on a file only where it leaves the size unchanged
            if (noisy && $urandom_range(0, 7) == 0 && (type_ch == DIR_CHAR || digit == 3'd0))
                blk[124+d] = non_octal_byte();
        end
        blk[156] = type_ch;
        for (int m = 0; m < 5; m++) blk[257+m] = MAGIC_WORD[8*(4-m) +: 8];
        if (magic_bad) begin
            k = $urandom_range(0, 4);
            blk[257+k] = blk[257+k] ^ 8'($urandom_range(1, 255));
        end
    endtask

    task automatic send_file(input logic [32:0] size_val, input bit noisy, input bit magic_bad,
                             input logic [7:0] type_ch);
        int nblk;
        build_header(type_ch, size_val, noisy, magic_bad);
        send_block();
        nblk = int'((34'(size_val) + 34'd511) >> 9);
        for (int i = 0; i < nblk; i++) begin
            fill_data($urandom_range(0, 5) == 0);
            send_block();
        end
    endtask

    task automatic send_dir(input logic [32:0] size_val, input bit noisy, input bit magic_bad);
        build_header(DIR_CHAR, size_val, noisy, magic_bad);
        send_block();
    endtask

    task automatic send_near_zero();
        int p;
        fill_data(1'b1);
        p = $urandom_range(0, 500);
        if (p >= 124) p = p + 11;
        blk[p] = 8'($urandom_range(1, 255));
        send_block();
    endtask

    function automatic logic [32:0] pick_file_size();
        case ($urandom_range(0, 9))
            0: return 33'd0;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 33'd1;
                    1: return 33'd511;
                    2: return 33'd512;
                    default: return 33'd513;
                endcase
            end
            9: return 33'($urandom_range(4097, 8192));
            default: return 33'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic logic [7:0] pick_file_type();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = "0";
            1: c = 8'h00;
            2: c = "2";
            default: begin
                c = 8'($urandom);
                if (c == DIR_CHAR) c = "1";
            end
        endcase
        return c;
    endfunction

    task automatic random_entry();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            fill_data(1'b1);
            send_block();
            send_file(pick_file_size(), $urandom_range(0, 3) == 0, 1'b0, pick_file_type());
        end else if (r < 16) begin
            send_near_zero();
        end else if (r < 40) begin
            send_dir({1'($urandom), 32'($urandom)}, $urandom_range(0, 3) == 0,
                     $urandom_range(0, 7) == 0);
        end else begin
            send_file(pick_file_size(), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0,
                      pick_file_type());
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        wait (pending_count == 0);
        @(negedge i_clk);
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // lone zero block, then a zero-size file
        fill_data(1'b1);
        send_block();
        send_file(33'd0, 1'b0, 1'b0, "0");
        send_file(33'd1, 1'b0, 1'b0, "0");
        send_file(33'd512, 1'b1, 1'b0, 8'h00);
        send_file(33'd513, 1'b0, 1'b1, "0");
        send_dir(33'h1_FFFF_FFFF, 1'b0, 1'b0);
        // size digits all non-octal
        build_header(DIR_CHAR, 33'd0, 1'b0, 1'b1);
        for (int d = 0; d < 11; d++) blk[124+d] = non_octal_byte();
        send_block();
        build_header("0", 33'd0, 1'b0, 1'b0);
        for (int d = 0; d < 11; d++) blk[124+d] = (d % 2) ? 8'hff : "8";
        send_block();
        // only the last byte of the block is non-zero
        fill_data(1'b1);
        blk[511] = 8'hff;
        send_block();
        fill_data(1'b1);
        send_block();
        send_dir(33'd777, 1'b0, 1'b0);
        // zero data blocks must not end the archive
        build_header("0", 33'd1536, 1'b0, 1'b0);
        send_block();
        fill_data(1'b1);
        send_block();
        send_block();
        fill_data(1'b0);
        send_block();
        drain();

        for (int n = 0; n < 20; n++) random_entry();

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int n = 0; n < 12; n++) random_entry();
        drain();

        // receiver holds off while headers keep coming
        hold_req = 1'b1;
        for (int n = 0; n < 10; n++)
            send_dir({1'($urandom), 32'($urandom)}, 1'b1, $urandom_range(0, 3) == 0);

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (int n = 0; n < 20; n++) random_entry();
        drain();

        // end of archive, then bytes that must be dropped
        fill_data(1'b1);
        send_block();
        send_block();
        for (int i = 0; i < 600; i++) send_byte(8'($urandom));
        push <= 1'b0;

        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
